// ----- rtl/scalar_kalman_filter_macros.svh -----
// Assertion macros for the scalar Kalman filter, clocked on clk_i, gated by rst_ni.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SKF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/skf_pkg.sv -----
// Package for the scalar Kalman filter: widths, register indexes and the microcode table.
package skf_pkg;

  localparam int DATA_W        = 32;
  localparam int NOISE_W       = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PC_W          = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSERVE_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,     // take a measurement word
    OP_MUL,      // product register <= ra * rb
    OP_RND,      // rd <= round and clamp of product register
    OP_ADD,      // rd <= clamp(ra + rb)
    OP_SUB,      // rd <= clamp(ra - rb)
    OP_DIVINIT,  // load divider with (|ra| << frac) + |rb|/2, |rb|
    OP_DIVSTEP,  // one quotient bit
    OP_DIVEND,   // rd <= signed, clamped quotient
    OP_OUT       // hand the estimate to the output register
  } op_e;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_A,
    SRC_H,
    SRC_Q,
    SRC_R,
    SRC_X,
    SRC_P,
    SRC_Z,
    SRC_T,
    SRC_PRED,
    SRC_PP,
    SRC_PH,
    SRC_DEN,
    SRC_G
  } src_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_ZERO,     // taken when ra reads zero
    JC_LOOP      // taken while divider bits remain
  } jc_e;

  typedef struct packed {
    op_e              op;
    src_e             ra;
    src_e             rb;
    src_e             rd;
    jc_e              jc;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // branch targets
  localparam logic [PC_W-1:0] UA_WAIT      = 5'd0;
  localparam logic [PC_W-1:0] UA_DIVSTEP   = 5'd15;
  localparam logic [PC_W-1:0] UA_ZERO_GAIN = 5'd17;
  localparam logic [PC_W-1:0] UA_RESID     = 5'd18;

  function automatic ucode_t mk(op_e op, src_e ra, src_e rb, src_e rd, jc_e jc,
                                logic [PC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.ra     = ra;
    w.rb     = rb;
    w.rd     = rd;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:  w = mk(OP_WAIT,    SRC_ZERO, SRC_ZERO, SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd1:  w = mk(OP_MUL,     SRC_A,    SRC_X,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd2:  w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_PRED, JC_NONE,   UA_WAIT);
      5'd3:  w = mk(OP_MUL,     SRC_A,    SRC_A,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd4:  w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_T,    JC_NONE,   UA_WAIT);
      5'd5:  w = mk(OP_MUL,     SRC_T,    SRC_P,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd6:  w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_T,    JC_NONE,   UA_WAIT);
      5'd7:  w = mk(OP_ADD,     SRC_T,    SRC_Q,    SRC_PP,   JC_NONE,   UA_WAIT);
      5'd8:  w = mk(OP_MUL,     SRC_PP,   SRC_H,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd9:  w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_PH,   JC_NONE,   UA_WAIT);
      5'd10: w = mk(OP_MUL,     SRC_PH,   SRC_H,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd11: w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_T,    JC_NONE,   UA_WAIT);
      5'd12: w = mk(OP_ADD,     SRC_T,    SRC_R,    SRC_DEN,  JC_NONE,   UA_WAIT);
      5'd13: w = mk(OP_NOP,     SRC_DEN,  SRC_ZERO, SRC_ZERO, JC_ZERO,   UA_ZERO_GAIN);
      5'd14: w = mk(OP_DIVINIT, SRC_PH,   SRC_DEN,  SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd15: w = mk(OP_DIVSTEP, SRC_ZERO, SRC_ZERO, SRC_ZERO, JC_LOOP,   UA_DIVSTEP);
      5'd16: w = mk(OP_DIVEND,  SRC_ZERO, SRC_ZERO, SRC_G,    JC_ALWAYS, UA_RESID);
      5'd17: w = mk(OP_ADD,     SRC_ZERO, SRC_ZERO, SRC_G,    JC_NONE,   UA_WAIT);
      5'd18: w = mk(OP_MUL,     SRC_H,    SRC_PRED, SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd19: w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_T,    JC_NONE,   UA_WAIT);
      5'd20: w = mk(OP_SUB,     SRC_Z,    SRC_T,    SRC_T,    JC_NONE,   UA_WAIT);
      5'd21: w = mk(OP_MUL,     SRC_T,    SRC_G,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd22: w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_T,    JC_NONE,   UA_WAIT);
      5'd23: w = mk(OP_ADD,     SRC_PRED, SRC_T,    SRC_X,    JC_NONE,   UA_WAIT);
      5'd24: w = mk(OP_MUL,     SRC_G,    SRC_H,    SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd25: w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_T,    JC_NONE,   UA_WAIT);
      5'd26: w = mk(OP_SUB,     SRC_ONE,  SRC_T,    SRC_T,    JC_NONE,   UA_WAIT);
      5'd27: w = mk(OP_MUL,     SRC_T,    SRC_PP,   SRC_ZERO, JC_NONE,   UA_WAIT);
      5'd28: w = mk(OP_RND,     SRC_ZERO, SRC_ZERO, SRC_P,    JC_NONE,   UA_WAIT);
      5'd29: w = mk(OP_OUT,     SRC_ZERO, SRC_ZERO, SRC_ZERO, JC_ALWAYS, UA_WAIT);
      default: w = mk(OP_NOP,   SRC_ZERO, SRC_ZERO, SRC_ZERO, JC_ALWAYS, UA_WAIT);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/skf_if.sv -----
// Handshake channels of the scalar Kalman filter: measurement in, estimate out, register writes.
interface skf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [skf_pkg::DATA_W-1:0]  measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [skf_pkg::DATA_W-1:0]  estimate;
  logic                               saturated;

  modport source (output valid, output estimate, output saturated, input ready);
  modport sink   (input valid, input estimate, input saturated, output ready);
endinterface

interface skf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [skf_pkg::CFG_IDX_W-1:0]      index;
  logic [skf_pkg::DATA_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/scalar_kalman_filter.sv -----
// Scalar Kalman filter: one measurement word in, one estimate word out per update.
// Each update runs the microcode once; a measurement is taken only while the sequencer waits,
// so a new word is accepted only after the previous estimate has been loaded into the output
// register. A zero denominator skips the divider, and a full output register stalls the update.
// The restoring divider, one quotient bit per cycle on the shared datapath, takes most of each update.
// Reset (rst_ni low, async): estimate 0, covariance 1.0, registers to their defaults.
`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  skf_cfg_if.sink      cfg_i,
  skf_in_if.sink       in_i,
  skf_out_if.source    out_o
);

  localparam int DW    = skf_pkg::DATA_W;
  localparam int NW    = skf_pkg::NOISE_W;
  localparam int NUM_W = DW + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic signed [DW-1:0]   ONE      = DW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [2*DW-1:0] HALF     = (2*DW)'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic [NW-1:0]          Q_RST    = NW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [NW-1:0]          R_RST    = NW'(64'd2 << FRAC_BITS);
  localparam logic signed [DW-1:0]   S_MAX    = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]   S_MIN    = {1'b1, {(DW-1){1'b0}}};
  localparam logic [CNT_W-1:0]       CNT_LAST = CNT_W'(1);

  // configuration
  logic signed [DW-1:0] a_q, h_q;
  logic [NW-1:0]        q_q, r_q;

  // working registers
  logic signed [DW-1:0] x_q, p_q, z_q, t_q, pred_q, pp_q, ph_q, den_q, g_q;
  logic signed [2*DW-1:0] prod_q;
  logic                 sat_q;

  // sequencer
  logic [skf_pkg::PC_W-1:0] pc_q, pc_d;
  skf_pkg::ucode_t          cw;

  // divider
  logic [NUM_W-1:0] dq_q;
  logic [DW-1:0]    drem_q, dvs_q;
  logic             dneg_q;
  logic [CNT_W-1:0] dcnt_q;

  // output register
  logic                 out_valid_q;
  logic signed [DW-1:0] out_est_q;
  logic                 out_sat_q;

  logic                 in_fire, out_load, taken;
  logic signed [DW-1:0] opa, opb;
  logic signed [DW-1:0] wb_data;
  logic                 wb_en, wb_clip;

  // rounding product
  logic signed [2*DW-1:0] rnd_sum, rnd_shr;
  logic                   rnd_ovf;
  // add and subtract
  logic signed [DW:0]     as_sum;
  // divider datapath
  logic [DW-1:0]    abs_a, abs_b;
  logic [NUM_W-1:0] dnum;
  logic [DW:0]      dshift;
  logic             dge;
  logic [DW:0]      ddiff;
  logic             dovf;
  logic [DW-1:0]    dres;

  assign cw = skf_pkg::ucode_rom(pc_q);

  function automatic logic signed [DW-1:0] src_val(
    skf_pkg::src_e sel,
    logic signed [DW-1:0] a, h, x, p, z, t, pred, pp, ph, den, g,
    logic [NW-1:0] q, r
  );
    logic signed [DW-1:0] v;
    case (sel)
      skf_pkg::SRC_ZERO: v = '0;
      skf_pkg::SRC_ONE:  v = ONE;
      skf_pkg::SRC_A:    v = a;
      skf_pkg::SRC_H:    v = h;
      skf_pkg::SRC_Q:    v = $signed({1'b0, q});
      skf_pkg::SRC_R:    v = $signed({1'b0, r});
      skf_pkg::SRC_X:    v = x;
      skf_pkg::SRC_P:    v = p;
      skf_pkg::SRC_Z:    v = z;
      skf_pkg::SRC_T:    v = t;
      skf_pkg::SRC_PRED: v = pred;
      skf_pkg::SRC_PP:   v = pp;
      skf_pkg::SRC_PH:   v = ph;
      skf_pkg::SRC_DEN:  v = den;
      skf_pkg::SRC_G:    v = g;
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = src_val(cw.ra, a_q, h_q, x_q, p_q, z_q, t_q, pred_q, pp_q, ph_q, den_q, g_q,
                  q_q, r_q);
    opb = src_val(cw.rb, a_q, h_q, x_q, p_q, z_q, t_q, pred_q, pp_q, ph_q, den_q, g_q,
                  q_q, r_q);
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (cw.op == skf_pkg::OP_WAIT);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_load    = (cw.op == skf_pkg::OP_OUT) && (!out_valid_q || out_o.ready);

  assign out_o.valid     = out_valid_q;
  assign out_o.estimate  = out_est_q;
  assign out_o.saturated = out_sat_q;

  // product rounding: add half an lsb, floor shift, clamp
  always_comb begin
    rnd_sum = prod_q + HALF;
    rnd_shr = rnd_sum >>> FRAC_BITS;
    rnd_ovf = (rnd_shr[2*DW-1:DW-1] != '0) && (rnd_shr[2*DW-1:DW-1] != '1);
  end

  // divider: magnitudes, one restoring step, final sign and clamp
  always_comb begin
    abs_a  = opa[DW-1] ? DW'(-opa) : DW'(opa);
    abs_b  = opb[DW-1] ? DW'(-opb) : DW'(opb);
    // |num| << frac plus half the divisor gives round half away from zero
    dnum   = {abs_a, {FRAC_BITS{1'b0}}} + NUM_W'(abs_b >> 1);
    dshift = {drem_q, dq_q[NUM_W-1]};
    dge    = dshift >= {1'b0, dvs_q};
    ddiff  = dshift - {1'b0, dvs_q};
    if (dneg_q) begin
      dovf = (dq_q[NUM_W-1:DW] != '0) || (dq_q[DW-1] && (dq_q[DW-2:0] != '0));
      dres = dovf ? S_MIN : DW'(-dq_q[DW-1:0]);
    end else begin
      dovf = (dq_q[NUM_W-1:DW-1] != '0);
      dres = dovf ? S_MAX : dq_q[DW-1:0];
    end
  end

  always_comb begin
    as_sum = (cw.op == skf_pkg::OP_SUB) ? ({opa[DW-1], opa} - {opb[DW-1], opb})
                                        : ({opa[DW-1], opa} + {opb[DW-1], opb});
    wb_en   = 1'b0;
    wb_clip = 1'b0;
    wb_data = '0;
    case (cw.op)
      skf_pkg::OP_RND: begin
        wb_en   = 1'b1;
        wb_clip = rnd_ovf;
        wb_data = rnd_ovf ? (rnd_shr[2*DW-1] ? S_MIN : S_MAX) : rnd_shr[DW-1:0];
      end
      skf_pkg::OP_ADD, skf_pkg::OP_SUB: begin
        wb_en   = 1'b1;
        wb_clip = as_sum[DW] != as_sum[DW-1];
        wb_data = wb_clip ? (as_sum[DW] ? S_MIN : S_MAX) : as_sum[DW-1:0];
      end
      skf_pkg::OP_DIVEND: begin
        wb_en   = 1'b1;
        wb_clip = dovf;
        wb_data = $signed(dres);
      end
      default: begin
        wb_en = 1'b0;
      end
    endcase
  end

  // sequencer: next step address
  always_comb begin
    case (cw.jc)
      skf_pkg::JC_ALWAYS: taken = 1'b1;
      skf_pkg::JC_ZERO:   taken = (opa == '0);
      skf_pkg::JC_LOOP:   taken = (dcnt_q != CNT_LAST);
      default:            taken = 1'b0;
    endcase
    if (cw.op == skf_pkg::OP_WAIT) begin
      pc_d = in_fire ? pc_q + 1'b1 : pc_q;
    end else if (cw.op == skf_pkg::OP_OUT) begin
      pc_d = out_load ? cw.target : pc_q;
    end else if (taken) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= skf_pkg::UA_WAIT;
      a_q         <= ONE;
      h_q         <= ONE;
      q_q         <= Q_RST;
      r_q         <= R_RST;
      x_q         <= '0;
      p_q         <= ONE;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      pc_q <= pc_d;

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          skf_pkg::CFG_STATE_GAIN:    a_q <= $signed(cfg_i.data);
          skf_pkg::CFG_OBSERVE_GAIN:  h_q <= $signed(cfg_i.data);
          skf_pkg::CFG_PROCESS_NOISE: q_q <= cfg_i.data[NW-1:0];
          skf_pkg::CFG_MEASURE_NOISE: r_q <= cfg_i.data[NW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        sat_q <= 1'b0;
      end else if (wb_en && wb_clip) begin
        sat_q <= 1'b1;
      end

      if (wb_en && (cw.rd == skf_pkg::SRC_X)) begin
        x_q <= wb_data;
      end
      if (wb_en && (cw.rd == skf_pkg::SRC_P)) begin
        p_q <= wb_data;
      end

      if (cw.op == skf_pkg::OP_DIVINIT) begin
        dcnt_q <= CNT_W'(NUM_W);
      end else if (cw.op == skf_pkg::OP_DIVSTEP) begin
        dcnt_q <= dcnt_q - 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      z_q <= in_i.measurement;
    end
    if (cw.op == skf_pkg::OP_MUL) begin
      prod_q <= opa * opb;
    end
    if (wb_en) begin
      case (cw.rd)
        skf_pkg::SRC_T:    t_q    <= wb_data;
        skf_pkg::SRC_PRED: pred_q <= wb_data;
        skf_pkg::SRC_PP:   pp_q   <= wb_data;
        skf_pkg::SRC_PH:   ph_q   <= wb_data;
        skf_pkg::SRC_DEN:  den_q  <= wb_data;
        skf_pkg::SRC_G:    g_q    <= wb_data;
        default: ;
      endcase
    end
    if (cw.op == skf_pkg::OP_DIVINIT) begin
      dq_q   <= dnum;
      drem_q <= '0;
      dvs_q  <= abs_b;
      dneg_q <= opa[DW-1] ^ opb[DW-1];
    end else if (cw.op == skf_pkg::OP_DIVSTEP) begin
      dq_q   <= {dq_q[NUM_W-2:0], dge};
      drem_q <= dge ? ddiff[DW-1:0] : dshift[DW-1:0];
    end
    if (out_load) begin
      out_est_q <= x_q;
      out_sat_q <= sat_q;
    end
  end

  `SKF_ASSERT_NEXT(a_out_from_seq, $rose(out_valid_q), $past(cw.op == skf_pkg::OP_OUT, 2), "estimate word raised without an output step")
  `SKF_ASSERT_NEXT(a_in_starts_prog, in_fire, pc_q == skf_pkg::UA_WAIT + 1'b1, "accepted measurement did not start the update")
  `SKF_ASSERT_SAME(a_div_count, cw.op == skf_pkg::OP_DIVSTEP, dcnt_q != '0, "divider stepped with no bits left")
  `SKF_ASSERT_SAME(a_div_nonzero, cw.op == skf_pkg::OP_DIVINIT, den_q != '0, "divider started on a zero denominator")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the scalar Kalman filter: directed corner cases, then random streams.
`timescale 1ns / 100ps

module tb;

  localparam int     FRAC              = skf_pkg::FRAC_BITS_DEF;
  localparam int     CLK_PERIOD        = 10;
  localparam int     RESET_CYCLES      = 7;
  localparam int     WATCHDOG_CYCLES   = 2000;
  localparam int     TAIL_CYCLES       = 100;
  localparam int     RAND_SETTINGS     = 4;
  localparam int     ITEMS_PER_SETTING = 108;
  localparam longint WORD_MAX          = 64'sd2147483647;
  localparam longint WORD_MIN          = -64'sd2147483648;
  localparam logic [31:0] ONE_Q        = 32'(64'd1 << FRAC);

  typedef logic signed [skf_pkg::DATA_W-1:0] fixed_t;
  typedef logic [skf_pkg::NOISE_W-1:0]       noise_t;
  typedef struct packed {
    fixed_t estimate;
    logic   saturated;
  } estimate_t;

  localparam fixed_t EXTREMES [6] = '{32'sh0000_0000, 32'sh0001_0000, -32'sh0001_0000,
                                      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  skf_in_if  in_if ();
  skf_out_if out_if ();
  skf_cfg_if cfg_if ();

  scalar_kalman_filter #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // filter model state and registers
  fixed_t reg_a   = fixed_t'(ONE_Q);
  fixed_t reg_h   = fixed_t'(ONE_Q);
  noise_t reg_q   = noise_t'((ONE_Q + 5) / 10);
  noise_t reg_r   = noise_t'(ONE_Q << 1);
  fixed_t est_x   = '0;
  fixed_t cov_p   = fixed_t'(ONE_Q);
  logic   clip_flag;

  estimate_t expected_q[$];
  int        n_fail      = 0;
  int        idle_cycles = 0;
  int        tx_idle_pct = 21;
  int        rx_idle_pct = 51;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic fixed_t sat_word(longint v);
    if (v > WORD_MAX) begin
      clip_flag = 1'b1;
      return fixed_t'(WORD_MAX);
    end
    if (v < WORD_MIN) begin
      clip_flag = 1'b1;
      return fixed_t'(WORD_MIN);
    end
    return fixed_t'(v);
  endfunction

  // round half up, floor shift
  function automatic fixed_t fmul(fixed_t a, fixed_t b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC - 1));
    return sat_word(p >>> FRAC);
  endfunction

  // quotient rounded to nearest, ties away from zero; zero divisor gives zero
  function automatic fixed_t fdiv_round(fixed_t num, fixed_t den);
    longint          n;
    longint unsigned un, ud, q;
    logic            neg;
    if (den == 0) return '0;
    n   = longint'(num) * (64'sd1 <<< FRAC);
    neg = 1'b0;
    if (n < 0) begin
      un  = -n;
      neg = 1'b1;
    end else begin
      un = n;
    end
    if (den < 0) begin
      ud  = -longint'(den);
      neg = ~neg;
    end else begin
      ud = longint'(den);
    end
    q = (un + ud / 2) / ud;
    return sat_word(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic estimate_t predict_estimate(fixed_t z);
    fixed_t    pred, aa, pp, ph, den, gain, resid, kh, one_m;
    estimate_t r;
    clip_flag = 1'b0;
    pred  = fmul(reg_a, est_x);
    aa    = fmul(reg_a, reg_a);
    pp    = sat_word(longint'(fmul(aa, cov_p)) + longint'(reg_q));
    ph    = fmul(pp, reg_h);
    den   = sat_word(longint'(fmul(ph, reg_h)) + longint'(reg_r));
    gain  = fdiv_round(ph, den);
    resid = sat_word(longint'(z) - longint'(fmul(reg_h, pred)));
    est_x = sat_word(longint'(pred) + longint'(fmul(resid, gain)));
    kh    = fmul(gain, reg_h);
    one_m = sat_word((64'sd1 <<< FRAC) - longint'(kh));
    cov_p = fmul(one_m, pp);
    r.estimate  = est_x;
    r.saturated = clip_flag;
    return r;
  endfunction

  function automatic void set_register(logic [skf_pkg::CFG_IDX_W-1:0] idx,
                                       logic [skf_pkg::DATA_W-1:0] data);
    case (idx)
      skf_pkg::CFG_STATE_GAIN:    reg_a = fixed_t'(data);
      skf_pkg::CFG_OBSERVE_GAIN:  reg_h = fixed_t'(data);
      skf_pkg::CFG_PROCESS_NOISE: reg_q = data[skf_pkg::NOISE_W-1:0];
      skf_pkg::CFG_MEASURE_NOISE: reg_r = data[skf_pkg::NOISE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic fixed_t random_measurement();
    case ($urandom_range(7))
      0: return fixed_t'($urandom);
      1: return EXTREMES[$urandom_range(5)];
      default: return fixed_t'(int'($urandom_range(32'h00C8_0000)) - 32'sh0064_0000);
    endcase
  endfunction

  always @(posedge clk_i) out_if.ready <= ($urandom_range(99) >= rx_idle_pct);

  // result check against the oldest pending estimate, then model updates
  always @(posedge clk_i) begin : monitor
    estimate_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          n_fail++;
          $error("estimate word with nothing pending: estimate %0d saturated %0b",
                 out_if.estimate, out_if.saturated);
        end else begin
          want = expected_q.pop_front();
          if (out_if.estimate !== want.estimate) begin
            n_fail++;
            $error("estimate: expected %0d, got %0d", want.estimate, out_if.estimate);
          end
          if (out_if.saturated !== want.saturated) begin
            n_fail++;
            $error("saturated: expected %0b, got %0b", want.saturated, out_if.saturated);
          end
        end
      end
      if (in_if.valid && in_if.ready)
        expected_q.push_back(predict_estimate(in_if.measurement));
      if (cfg_if.valid && cfg_if.ready)
        set_register(cfg_if.index, cfg_if.data);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_measurement(fixed_t z);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.measurement <= z;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic pause_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [skf_pkg::CFG_IDX_W-1:0] idx,
                                logic [skf_pkg::DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  // only with the filter idle: input paused and every estimate back
  task automatic write_registers(fixed_t a, fixed_t h, logic [31:0] q, logic [31:0] r);
    pause_input();
    wait_drained();
    write_register(skf_pkg::CFG_STATE_GAIN, a);
    write_register(skf_pkg::CFG_OBSERVE_GAIN, h);
    write_register(skf_pkg::CFG_PROCESS_NOISE, q);
    write_register(skf_pkg::CFG_MEASURE_NOISE, r);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    fixed_t zs [7] = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       32'sh0001_0000, -32'sh0001_0000};
    foreach (zs[i]) send_measurement(zs[i]);
  endtask

  // H = 0 and R = 0; top bit of the noise words must be dropped
  task automatic test_zero_denominator();
    write_registers('0, '0, 32'h8000_0000, 32'h8000_0000);
    send_measurement(32'sh0005_0000);
    send_measurement(-32'sh0003_0000);
    send_measurement(32'sh7FFF_FFFF);
  endtask

  // a clipped denominator pushes the gain term past one: covariance and then
  // the denominator go negative
  task automatic test_negative_covariance();
    write_registers(fixed_t'(ONE_Q), 32'sh7FFF_FFFF, ONE_Q, 32'h0);
    send_measurement(32'sh0001_0000);
    send_measurement(-32'sh0001_0000);
    send_measurement(32'sh0064_0000);
    send_measurement(32'sh8000_0000);
  endtask

  task automatic test_saturation();
    write_registers(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sd0);
    send_measurement(32'sh7FFF_FFFF);
  endtask

  task automatic test_random_streams();
    fixed_t      a, h;
    logic [31:0] q, r;
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 51 : 0;
      rx_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 21 : 0;
      for (int s = 0; s < RAND_SETTINGS; s++) begin
        case (s)
          1: begin
            a = fixed_t'($urandom);
            h = fixed_t'($urandom);
            q = $urandom;
            r = $urandom;
          end
          2: begin
            a = EXTREMES[$urandom_range(5)];
            h = EXTREMES[$urandom_range(5)];
            q = EXTREMES[$urandom_range(5)];
            r = EXTREMES[$urandom_range(5)];
          end
          default: begin
            // well-behaved tracking filter
            a = fixed_t'(int'(ONE_Q) + int'($urandom_range(13108)) - 6554);
            h = fixed_t'(int'(ONE_Q) + int'($urandom_range(65536)) - 32768);
            q = {1'($urandom_range(1)), 31'($urandom_range(65536))};
            r = {1'($urandom_range(1)), 31'($urandom_range(16 * 65536, 1))};
          end
        endcase
        write_registers(a, h, q, r);
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          if ($urandom_range(149) == 0) begin
            pause_input();
            wait_drained();
          end
          send_measurement(random_measurement());
        end
      end
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.measurement <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= skf_pkg::CFG_STATE_GAIN;
    cfg_if.data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_denominator();
    test_negative_covariance();
    test_saturation();
    test_random_streams();

    pause_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/skf_pkg.sv
rtl/skf_if.sv
rtl/scalar_kalman_filter.sv
sim/tb.sv
